[rtl/slpt_pkg.sv]
// Package for the software-loaded page translator: shared widths, opcodes,
// register selectors and the controller-to-datapath command struct.
// It has no dependencies; every other file of the block refers to it.
package slpt_pkg;

  localparam int ADDR_W           = 32;
  localparam int OPCODE_W         = 3;
  localparam int INDEX_W          = 5;
  localparam int ENTRY_COUNT_DEF  = 32;
  localparam int PAGE_SHIFT_DEF   = 12;

  localparam logic [OPCODE_W-1:0] OP_TRANSLATE = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_WRITE_VPN = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_WRITE_PPN = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_ENABLE    = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_ACTIVATE  = 3'd4;
  localparam logic [OPCODE_W-1:0] OP_VALID     = 3'd5;
  localparam logic [OPCODE_W-1:0] OP_READ_REG  = 3'd6;

  localparam logic [INDEX_W-1:0] REG_ACTIVATE = 5'd0;
  localparam logic [INDEX_W-1:0] REG_VALID    = 5'd1;
  localparam logic [INDEX_W-1:0] REG_ENABLE   = 5'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;   // a transaction is taken from the input channel this cycle
    logic resolve;  // pick the winning entry of the captured hit vector
  } ctrl_cmd_t;

endpackage

[rtl/software_loaded_page_translator_core.sv]
// Top level of the software-loaded page translator.
// Instantiates slpt_controller and slpt_datapath; depends on slpt_pkg.
//
// Usage: one input channel (in_valid/in_ready) carries a transaction made of
// opcode, entry_index, write_value and lookup_address. Opcodes 1 through 5
// load the staging page tables and the enable, activate and valid registers
// and produce no output transaction. Writing enable or activate commits the
// staging tables and the enable mask to the active mapping when activate is
// nonzero afterward. Opcode 0 translates lookup_address and opcode 6 reads a
// register; each returns one output transaction (result_value, matched,
// match_index) on out_valid/out_ready. Opcode 7 is taken and ignored.
//
// Timing: the block works on one transaction at a time. A table or register
// write is stored when it is accepted, and the block stays ready. A read
// registers its result on acceptance and shows it in the cycle after; a
// translation registers the hit vector of the parallel comparators on
// acceptance, then the lowest-index pick in the resolve state. The next
// transaction is taken in the cycle after the result is handed over.
// If the receiver stalls, the result stays in its output register and
// in_ready stays low. Reset clears all tables and control registers: with an empty
// enable mask every address translates to itself.
module software_loaded_page_translator_core #(
  parameter int ENTRY_COUNT = slpt_pkg::ENTRY_COUNT_DEF,
  parameter int PAGE_SHIFT  = slpt_pkg::PAGE_SHIFT_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [slpt_pkg::OPCODE_W-1:0]   opcode,
  input  logic [slpt_pkg::INDEX_W-1:0]    entry_index,
  input  logic [slpt_pkg::ADDR_W-1:0]     write_value,
  input  logic [slpt_pkg::ADDR_W-1:0]     lookup_address,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [slpt_pkg::ADDR_W-1:0]     result_value,
  output logic                            matched,
  output logic [slpt_pkg::INDEX_W-1:0]    match_index
);

  slpt_pkg::ctrl_cmd_t cmd;

  // The controller sequences each transaction and owns both handshakes.
  slpt_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .opcode    (opcode),
    .out_ready (out_ready),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  // The datapath holds all mapping state and the output register.
  slpt_datapath #(
    .ENTRY_COUNT (ENTRY_COUNT),
    .PAGE_SHIFT  (PAGE_SHIFT)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .opcode         (opcode),
    .entry_index    (entry_index),
    .write_value    (write_value),
    .lookup_address (lookup_address),
    .result_value   (result_value),
    .matched        (matched),
    .match_index    (match_index)
  );

endmodule

[rtl/slpt_controller.sv]
// Controller of the page translator: a three-state machine that owns the
// handshakes and issues commands to the datapath. Depends on slpt_pkg.
module slpt_controller (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  input  logic [slpt_pkg::OPCODE_W-1:0]   opcode,
  input  logic                            out_ready,
  output logic                            in_ready,
  output logic                            out_valid,
  output slpt_pkg::ctrl_cmd_t             cmd
);

  localparam logic [1:0] S_IDLE    = 2'd0;
  localparam logic [1:0] S_RESOLVE = 2'd1;
  localparam logic [1:0] S_HOLD    = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  assign in_ready    = (state == S_IDLE);
  assign out_valid   = (state == S_HOLD);
  assign cmd.accept  = in_valid && in_ready;
  assign cmd.resolve = (state == S_RESOLVE);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (cmd.accept) begin
          if (opcode == slpt_pkg::OP_TRANSLATE) begin
            state_next = S_RESOLVE;
          end else if (opcode == slpt_pkg::OP_READ_REG) begin
            state_next = S_HOLD;
          end
        end
      end
      S_RESOLVE: state_next = S_HOLD;
      S_HOLD: begin
        if (out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

[rtl/slpt_datapath.sv]
// Datapath of the page translator: staging and active page tables, control
// registers, parallel comparators and the priority pick. Depends on slpt_pkg.
module slpt_datapath #(
  parameter int ENTRY_COUNT = slpt_pkg::ENTRY_COUNT_DEF,
  parameter int PAGE_SHIFT  = slpt_pkg::PAGE_SHIFT_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  slpt_pkg::ctrl_cmd_t             cmd,
  input  logic [slpt_pkg::OPCODE_W-1:0]   opcode,
  input  logic [slpt_pkg::INDEX_W-1:0]    entry_index,
  input  logic [slpt_pkg::ADDR_W-1:0]     write_value,
  input  logic [slpt_pkg::ADDR_W-1:0]     lookup_address,
  output logic [slpt_pkg::ADDR_W-1:0]     result_value,
  output logic                            matched,
  output logic [slpt_pkg::INDEX_W-1:0]    match_index
);

  localparam int PAGE_W = slpt_pkg::ADDR_W - PAGE_SHIFT;
  localparam int IDX_W  = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;

  logic [PAGE_W-1:0]               staged_vpn [ENTRY_COUNT];
  logic [PAGE_W-1:0]               staged_ppn [ENTRY_COUNT];
  logic [PAGE_W-1:0]               active_vpn [ENTRY_COUNT];
  logic [PAGE_W-1:0]               active_ppn [ENTRY_COUNT];
  logic [ENTRY_COUNT-1:0]          active_mask;
  logic [slpt_pkg::ADDR_W-1:0]     enable_reg;
  logic [slpt_pkg::ADDR_W-1:0]     activate_reg;
  logic [slpt_pkg::ADDR_W-1:0]     valid_reg;
  logic [ENTRY_COUNT-1:0]          hit_vec;
  logic [slpt_pkg::ADDR_W-1:0]     lookup_addr;

  logic [PAGE_W-1:0]               page_in;
  logic [ENTRY_COUNT-1:0]          hit_now;
  logic [ENTRY_COUNT-1:0]          first_hit;
  logic [PAGE_W-1:0]               sel_ppn;
  logic [slpt_pkg::INDEX_W-1:0]    sel_idx;
  logic                            index_ok;
  logic [slpt_pkg::ADDR_W-1:0]     enable_after;
  logic [slpt_pkg::ADDR_W-1:0]     activate_after;
  logic                            commit;
  logic [slpt_pkg::ADDR_W-1:0]     reg_value;

  assign page_in = lookup_address[slpt_pkg::ADDR_W-1:PAGE_SHIFT];

  // One comparator per entry; all compare against the incoming page.
  always_comb begin
    for (int i = 0; i < ENTRY_COUNT; i++) begin
      hit_now[i] = active_mask[i] && (active_vpn[i] == page_in);
    end
  end

  // Isolate the lowest set hit so that the lowest index wins, then AND-OR select.
  assign first_hit = hit_vec & (~hit_vec + 1'b1);

  always_comb begin
    sel_ppn = '0;
    sel_idx = '0;
    for (int i = 0; i < ENTRY_COUNT; i++) begin
      sel_ppn = sel_ppn | (first_hit[i] ? active_ppn[i] : '0);
      sel_idx = sel_idx | (first_hit[i] ? slpt_pkg::INDEX_W'(i) : '0);
    end
  end

  assign index_ok = ({1'b0, entry_index} < (slpt_pkg::INDEX_W + 1)'(ENTRY_COUNT));

  assign enable_after   = (opcode == slpt_pkg::OP_ENABLE)   ? write_value : enable_reg;
  assign activate_after = (opcode == slpt_pkg::OP_ACTIVATE) ? write_value : activate_reg;
  assign commit = cmd.accept && (activate_after != '0) &&
                  ((opcode == slpt_pkg::OP_ENABLE) || (opcode == slpt_pkg::OP_ACTIVATE));

  always_comb begin
    case (entry_index)
      slpt_pkg::REG_ACTIVATE: reg_value = activate_reg;
      slpt_pkg::REG_VALID:    reg_value = valid_reg;
      slpt_pkg::REG_ENABLE:   reg_value = enable_reg;
      default:                reg_value = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ENTRY_COUNT; i++) begin
        staged_vpn[i] <= '0;
        staged_ppn[i] <= '0;
        active_vpn[i] <= '0;
        active_ppn[i] <= '0;
      end
      active_mask  <= '0;
      enable_reg   <= '0;
      activate_reg <= '0;
      valid_reg    <= '0;
    end else if (cmd.accept) begin
      if ((opcode == slpt_pkg::OP_WRITE_VPN) && index_ok) begin
        staged_vpn[entry_index[IDX_W-1:0]] <= write_value[PAGE_W-1:0];
      end
      if ((opcode == slpt_pkg::OP_WRITE_PPN) && index_ok) begin
        staged_ppn[entry_index[IDX_W-1:0]] <= write_value[PAGE_W-1:0];
      end
      if (opcode == slpt_pkg::OP_ENABLE) begin
        enable_reg <= write_value;
      end
      if (opcode == slpt_pkg::OP_ACTIVATE) begin
        activate_reg <= write_value;
      end
      if (opcode == slpt_pkg::OP_VALID) begin
        valid_reg <= write_value;
      end
      if (commit) begin
        for (int i = 0; i < ENTRY_COUNT; i++) begin
          active_vpn[i] <= staged_vpn[i];
          active_ppn[i] <= staged_ppn[i];
        end
        active_mask <= enable_after[ENTRY_COUNT-1:0];
      end
    end
  end

  // Lookup capture, priority resolve and the output register.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      hit_vec     <= hit_now;
      lookup_addr <= lookup_address;
      if (opcode == slpt_pkg::OP_READ_REG) begin
        result_value <= reg_value;
        matched      <= 1'b0;
        match_index  <= '0;
      end
    end
    if (cmd.resolve) begin
      matched     <= |hit_vec;
      match_index <= sel_idx;
      if (|hit_vec) begin
        result_value <= {sel_ppn, lookup_addr[PAGE_SHIFT-1:0]};
      end else begin
        result_value <= lookup_addr;
      end
    end
  end

endmodule

[rtl/slpt_checker.sv]
// Port-level checker for the page translator, bound to the top level.
// Depends on slpt_pkg and software_loaded_page_translator_core.
module slpt_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic [slpt_pkg::OPCODE_W-1:0]   opcode,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [slpt_pkg::ADDR_W-1:0]     result_value,
  input logic                            matched,
  input logic [slpt_pkg::INDEX_W-1:0]    match_index
);

  // A pending result blocks the input channel.
  assert property (@(posedge clk) disable iff (rst) !(in_ready && out_valid))
    else $error("input taken while a result is pending");

  // A stalled result holds its payload.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(result_value) &&
    $stable(matched) && $stable(match_index))
    else $error("stalled result changed");

  // A translation delivers its result right after the resolve state that follows acceptance.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (opcode == slpt_pkg::OP_TRANSLATE) |-> ##2 out_valid)
    else $error("translation result late");

  // A register read answers in the next cycle and never reports a match.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (opcode == slpt_pkg::OP_READ_REG) |=>
    out_valid && !matched && (match_index == '0))
    else $error("register read result wrong");

  // A miss always reports entry zero.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !matched |-> (match_index == '0))
    else $error("miss with nonzero index");

endmodule

bind software_loaded_page_translator_core slpt_checker u_slpt_checker (.*);
